@@ hw/rtl/ssfe_pkg.sv @@
// shared types, constants and helpers for the scheduled screen fade engine
// no dependencies; every other rtl file but ssfe_ram imports this package
package ssfe_pkg;

	// cue table geometry
	localparam int CUE_SLOTS = 32;
	localparam int SLOT_W    = $clog2(CUE_SLOTS);

	// item kinds
	localparam logic [1:0] K_LOAD  = 2'd0;
	localparam logic [1:0] K_START = 2'd1;
	localparam logic [1:0] K_NEXT  = 2'd2;
	localparam logic [1:0] K_TICK  = 2'd3;

	// fade kinds
	localparam logic [1:0] FT_OUT   = 2'd0;
	localparam logic [1:0] FT_BLACK = 2'd1;
	localparam logic [1:0] FT_WHITE = 2'd2;
	localparam logic [1:0] FT_RED   = 2'd3;

	localparam logic [23:0] COL_BLACK = 24'h000000;
	localparam logic [23:0] COL_WHITE = 24'hffffff;
	localparam logic [23:0] COL_RED   = 24'hff0000;

	// ramp arithmetic, fraction in q1.16
	localparam logic [16:0] FRAC_ONE  = 17'h10000;
	localparam logic [16:0] RATE_SAT  = 17'h1ffff;
	localparam logic [15:0] HOLD_BIAS = 16'h0040;
	localparam logic [15:0] LEN_TRIM  = 16'd4;
	localparam logic [15:0] LEN_MIN   = 16'd5;

	// reciprocal divider: quotient bits of 65536 / len
	localparam int RECIP_STEPS = 17;
	localparam int RECIP_CNT_W = $clog2(RECIP_STEPS);

	typedef struct packed {
		logic [1:0]         kind;
		logic [4:0]         cue_slot;
		logic [7:0]         cue_scene;
		logic [1:0]         cue_fade_type;
		logic [15:0]        cue_start;
		logic [15:0]        cue_length;
		logic signed [15:0] cue_hold;
		logic [15:0]        tick_delta;
	} cue_item_t;

	typedef struct packed {
		logic       draw;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} fade_result_t;

	// one stored cue table entry
	typedef struct packed {
		logic [7:0]  scene;
		logic [1:0]  fade_type;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] hold;
	} cue_t;

	localparam int CUE_W = $bits(cue_t);

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic eval;
		logic ramp;
		logic acc;
		logic emit;
	} ssfe_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic fire;
		logic len_zero;
		logic div_done;
	} ssfe_stat_t;

	// slot number modulo the table depth, by at most three conditional subtracts
	function automatic logic [SLOT_W-1:0] slot_mod(input logic [4:0] s);
		logic [8:0] r;
		r = {4'd0, s};
		for (int k = 2; k >= 0; k--) begin
			if (int'(r) >= (CUE_SLOTS << k)) begin
				r = r - 9'(CUE_SLOTS << k);
			end
		end
		return r[SLOT_W-1:0];
	endfunction

endpackage

@@ hw/rtl/ssfe_ram.sv @@
// generic single write port ram with registered read
// depends on nothing
module ssfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/ssfe_recip.sv @@
// serial restoring divider computing 65536 / divisor, one quotient bit a cycle
// depends on ssfe_pkg
module ssfe_recip
	import ssfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [16:0] quotient
);

	logic                   active_q;
	logic [RECIP_CNT_W-1:0] cnt_q;
	logic [15:0]            div_q;
	logic [15:0]            rem_q;
	logic [15:0]            quo_q;
	logic [16:0]            trial;
	logic                   qbit;
	logic [15:0]            rem_next;

	// dividend is a single one in bit 16; the remainder always fits below the divisor
	always_comb begin
		trial    = {rem_q, (cnt_q == RECIP_CNT_W'(RECIP_STEPS - 1))};
		qbit     = (trial >= {1'b0, div_q});
		rem_next = qbit ? 16'(trial - {1'b0, div_q}) : trial[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (go) begin
			active_q <= 1'b1;
			cnt_q    <= RECIP_CNT_W'(RECIP_STEPS - 1);
		end else if (active_q) begin
			if (cnt_q == '0) begin
				active_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (active_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[14:0], qbit};
		end
	end

	assign done     = active_q && (cnt_q == '0);
	assign quotient = {quo_q, qbit};

endmodule

@@ hw/rtl/ssfe_datapath.sv @@
// datapath: cue table, timers, reciprocal divider, ramp multiply and clamp, result register
// depends on ssfe_pkg, ssfe_ram, ssfe_recip
module ssfe_datapath
	import ssfe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cue_item_t    item,
	input  ssfe_cmd_t    cmd,
	output ssfe_stat_t   stat,
	output logic         done,
	output fade_result_t result
);

	cue_item_t           item_q;
	logic [SLOT_W-1:0]   ptr_q;
	logic [15:0]         scene_time_q;
	logic [15:0]         scene_count_q;
	logic [15:0]         fade_rem_q;
	logic [16:0]         frac_q;
	logic signed [17:0]  rate_q;
	logic [23:0]         colour_q;
	logic                neg_q;
	logic [15:0]         elapsed_q;
	logic                ramp_act_s1;
	logic signed [34:0]  prod_s1;
	logic                done_q;
	fade_result_t        result_q;

	cue_t                wr_cue;
	logic [CUE_W-1:0]    rd_data;
	cue_t                cue;
	logic                ram_we;
	logic [15:0]         new_time;
	logic [16:0]         start2;
	logic                fire;
	logic [15:0]         len_base;
	logic [15:0]         hold_base;
	logic                trim;
	logic [15:0]         fire_len;
	logic [15:0]         fire_hold;
	logic                len_zero;
	logic                div_go;
	logic                div_done;
	logic [16:0]         quotient;
	logic signed [17:0]  quo_mag;
	logic signed [17:0]  sat_mag;
	logic [15:0]         rem_diff;
	logic signed [35:0]  acc_sum;
	logic [16:0]         frac_next;
	logic [24:0]         alpha_prod;
	logic [7:0]          alpha;

	always_comb begin
		wr_cue.scene     = item_q.cue_scene;
		wr_cue.fade_type = item_q.cue_fade_type;
		wr_cue.start     = item_q.cue_start;
		wr_cue.length    = item_q.cue_length;
		wr_cue.hold      = item_q.cue_hold;
	end

	assign ram_we = cmd.exec && (item_q.kind == K_LOAD);

	ssfe_ram #(
		.WIDTH(CUE_W),
		.DEPTH(CUE_SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_mod(item_q.cue_slot)),
		.wdata(wr_cue),
		.raddr(ptr_q),
		.rdata(rd_data)
	);

	// cue firing test and fade setup
	always_comb begin
		cue       = cue_t'(rd_data);
		new_time  = scene_time_q + item_q.tick_delta;
		start2    = {cue.start, 1'b0};
		fire      = (cue.scene != 8'd0) && ({8'd0, cue.scene} == scene_count_q) &&
			({1'b0, new_time} >= start2) && (start2 >= {1'b0, scene_time_q});
		len_base  = {cue.length[14:0], 1'b0};
		hold_base = {cue.hold[14:0], 1'b0};
		trim      = (cue.length >= LEN_MIN);
		fire_len  = trim ? (len_base - LEN_TRIM) : len_base;
		fire_hold = trim ? (hold_base + HOLD_BIAS) : hold_base;
		len_zero  = (fire_len == 16'd0);
		sat_mag   = $signed({1'b0, RATE_SAT});
		quo_mag   = $signed({1'b0, quotient});
	end

	assign div_go = cmd.eval && fire && !len_zero;

	ssfe_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go),
		.divisor (fire_len),
		.done    (div_done),
		.quotient(quotient)
	);

	// ramp accumulate, clamp to [0, 1], alpha scale by 255
	always_comb begin
		rem_diff   = fade_rem_q - elapsed_q;
		acc_sum    = $signed({19'd0, frac_q}) + 36'(prod_s1);
		if (acc_sum < 36'sd0) begin
			frac_next = '0;
		end else if (acc_sum > 36'sh10000) begin
			frac_next = FRAC_ONE;
		end else begin
			frac_next = acc_sum[16:0];
		end
		alpha_prod = {frac_q, 8'd0} - {8'd0, frac_q};
		alpha      = alpha_prod[23:16];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item;
		end
		if (cmd.eval) begin
			elapsed_q <= fire ? (new_time - start2[15:0]) : item_q.tick_delta;
		end
		if (cmd.ramp) begin
			prod_s1 <= 35'(rate_q) * 35'($signed({1'b0, elapsed_q}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q         <= '0;
			scene_time_q  <= '0;
			scene_count_q <= '0;
			fade_rem_q    <= '0;
			frac_q        <= '0;
			rate_q        <= '0;
			colour_q      <= '0;
			neg_q         <= 1'b0;
			ramp_act_s1   <= 1'b0;
			done_q        <= 1'b0;
			result_q      <= '0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.exec && (item_q.kind == K_START)) begin
				ptr_q         <= slot_mod(item_q.cue_slot);
				scene_time_q  <= '0;
				scene_count_q <= '0;
				fade_rem_q    <= '0;
				frac_q        <= '0;
				rate_q        <= '0;
				colour_q      <= '0;
			end
			if (cmd.exec && (item_q.kind == K_NEXT)) begin
				scene_time_q  <= '0;
				scene_count_q <= scene_count_q + 1'b1;
			end
			if (cmd.eval) begin
				scene_time_q <= new_time;
				if (fire) begin
					fade_rem_q <= fire_hold + fire_len;
					neg_q      <= (cue.fade_type == FT_OUT);
					ptr_q      <= (ptr_q == SLOT_W'(CUE_SLOTS - 1)) ? '0 : ptr_q + 1'b1;
					if (len_zero) begin
						rate_q <= (cue.fade_type == FT_OUT) ? -sat_mag : sat_mag;
					end
					case (cue.fade_type)
						FT_OUT: begin
							frac_q <= FRAC_ONE;
						end
						FT_BLACK: begin
							colour_q <= COL_BLACK;
							frac_q   <= '0;
						end
						FT_WHITE: begin
							colour_q <= COL_WHITE;
							frac_q   <= '0;
						end
						default: begin
							colour_q <= COL_RED;
							frac_q   <= '0;
						end
					endcase
				end
			end
			if (div_done) begin
				rate_q <= neg_q ? -quo_mag : quo_mag;
			end
			if (cmd.ramp) begin
				ramp_act_s1 <= (fade_rem_q != 16'd0);
				if (fade_rem_q != 16'd0) begin
					fade_rem_q <= rem_diff[15] ? 16'd0 : rem_diff;
				end
			end
			if (cmd.acc && ramp_act_s1) begin
				frac_q <= frac_next;
			end
			if (cmd.emit) begin
				if ((item_q.kind == K_TICK) && ramp_act_s1 && (alpha != 8'd0)) begin
					result_q.draw  <= 1'b1;
					result_q.red   <= colour_q[23:16];
					result_q.green <= colour_q[15:8];
					result_q.blue  <= colour_q[7:0];
					result_q.alpha <= alpha;
				end else begin
					result_q <= '0;
				end
			end
		end
	end

	always_comb begin
		stat.is_tick  = (item_q.kind == K_TICK);
		stat.fire     = fire;
		stat.len_zero = len_zero;
		stat.div_done = div_done;
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTH
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		frac_q <= FRAC_ONE)
		else $error("ramp fraction above one");
	a_done_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.emit))
		else $error("result strobe without emit");
	a_sat_rate: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval && fire && len_zero |=> rate_q != 18'sd0)
		else $error("zero length fade left rate at zero");
`endif

endmodule

@@ hw/rtl/ssfe_ctrl.sv @@
// controller state machine sequencing decode, cue evaluation, divide, ramp and result
// depends on ssfe_pkg
module ssfe_ctrl
	import ssfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  ssfe_stat_t stat,
	output ssfe_cmd_t  cmd,
	output logic       busy
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EXEC = 7'b0000010,
		S_EVAL = 7'b0000100,
		S_DIV  = 7'b0001000,
		S_RAMP = 7'b0010000,
		S_ACC  = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = stat.is_tick ? S_EVAL : S_EMIT;
			end
			S_EVAL: begin
				state_d = (stat.fire && !stat.len_zero) ? S_DIV : S_RAMP;
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_RAMP;
				end
			end
			S_RAMP: begin
				state_d = S_ACC;
			end
			S_ACC: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd.accept = (state_q == S_IDLE) && start;
		cmd.exec   = (state_q == S_EXEC);
		cmd.eval   = (state_q == S_EVAL);
		cmd.ramp   = (state_q == S_RAMP);
		cmd.acc    = (state_q == S_ACC);
		cmd.emit   = (state_q == S_EMIT);
	end

	assign busy = (state_q != S_IDLE);

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");
	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |=> state_q == S_IDLE)
		else $error("result emitted for more than one cycle");
	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> $past(state_q == S_EVAL) || $past(state_q == S_DIV))
		else $error("divide entered from wrong state");
`endif

endmodule

@@ hw/rtl/scheduled_screen_fade_engine.sv @@
// top level of the scheduled screen fade engine: controller plus datapath
// depends on ssfe_pkg, ssfe_ctrl, ssfe_datapath
//
// item flow: an item is taken on a rising edge with start high and busy low, and
// exactly one result comes back per item as a one-cycle done strobe on result.
// the receiver cannot stall, so result must be captured in the done cycle.
// load, start-sequence and next-scene items go through the exec and emit states;
// a tick also goes through eval, ramp and acc, and through a divide state when it
// fires a cue with a nonzero fade length: the reciprocal of the fade length comes
// from a serial divider producing one of its 17 quotient bits per cycle. busy drops
// in the done cycle, so the next item can be accepted while the result is on the ports.
// the cue table is a 32 entry ram, read through a registered port; entries that
// were never loaded hold no defined value and must not be reached by the cue
// pointer.
module scheduled_screen_fade_engine
	import ssfe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  cue_item_t    item,
	output logic         done,
	output fade_result_t result
);

	ssfe_cmd_t  cmd;
	ssfe_stat_t stat;

	// sequencing: decode, cue check, optional divide, ramp multiply, clamp, result
	ssfe_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	// cue table, timers, divider, ramp arithmetic and the result register
	ssfe_datapath u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.stat  (stat),
		.done  (done),
		.result(result)
	);

endmodule
